// ===== rtl/blocking_standard_error_unit_assert.svh =====
// assertion macros shared by the blocking standard error unit
// depends on nothing; included by the files that carry assertions
`ifndef BLOCKING_STANDARD_ERROR_UNIT_ASSERT_SVH
`define BLOCKING_STANDARD_ERROR_UNIT_ASSERT_SVH

// same-cycle implication
`define BSEU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bseu assertion failed");

// next-cycle implication
`define BSEU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bseu assertion failed");

`endif

// ===== rtl/bseu_pkg.sv =====
// shared types for the blocking standard error unit
// beat structs, datapath opcodes and status; no dependencies
package bseu_pkg;

   localparam int SAMPLE_FIELD_W = 32;
   localparam int STD_W          = 32;
   localparam int LEVEL_W        = 4;

   typedef struct packed {
      logic signed [SAMPLE_FIELD_W-1:0] sample;
      logic                             last;
   } req_beat_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [STD_W-1:0]   std_error;
      logic               defined;
      logic               overflowed;
      logic               final_res;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_STORE,
      OP_SETUP,
      OP_LVL_INIT,
      OP_READ,
      OP_ACC,
      OP_SQ_STEP,
      OP_BLK_ADD,
      OP_NUM,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_OUT_DEF,
      OP_OUT_UNDEF,
      OP_NEXT
   } dp_op_type;

   typedef struct packed {
      logic lvl_top;
      logic blk_end;
      logic sweep_end;
      logic sq_done;
      logic div_done;
      logic root_done;
   } dp_status_type;

endpackage

// ===== rtl/blocking_standard_error_unit.sv =====
// top level of the blocking standard error unit
// depends on bseu_pkg, bseu_ctrl and bseu_datapath
//
//   channel  handshake              payload
//   req      req_valid/req_ready    req_beat  (sample, last)
//   rsp      rsp_valid/rsp_ready    rsp_beat  (level, std_error, defined, overflowed, final_res)
//
// loading takes one sample beat per cycle; the last beat is followed by the setup state
// level k with m = P >> k >= 2 blocks reads and adds each sample, squares each block sum
//   in the serial squarer, then squares the total, divides and takes the root;
//   the one-block top level goes straight to an undefined final result
// req_ready is low from the last beat until the final result beat is taken
// a stalled result holds the unit; synchronous active-high reset, no clearing pass
module blocking_standard_error_unit #(
   parameter int MAX_SAMPLES  = 4096,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bseu_pkg::req_beat_type req_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bseu_pkg::rsp_beat_type rsp_beat
);
   import bseu_pkg::*;

   dp_op_type     op;
   dp_status_type sts;
   logic          finish;

   // sequencing
   bseu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_beat.last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .op        (op),
      .finish    (finish)
   );

   // storage and arithmetic
   bseu_datapath #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_beat (req_beat),
      .op       (op),
      .finish   (finish),
      .sts      (sts),
      .rsp_beat (rsp_beat)
   );

endmodule

// ===== rtl/bseu_datapath.sv =====
// datapath: sample memory, block sums, serial squarer, divider and root
// depends on bseu_pkg
module bseu_datapath #(
   parameter int MAX_SAMPLES  = 4096,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bseu_pkg::req_beat_type          req_beat,
   input  bseu_pkg::dp_op_type             op,
   input  logic                            finish,
   output bseu_pkg::dp_status_type         sts,
   output bseu_pkg::rsp_beat_type          rsp_beat
);
   import bseu_pkg::*;

   localparam int SW   = SAMPLE_WIDTH;
   localparam int AW   = $clog2(MAX_SAMPLES);
   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int LW   = $clog2(AW);
   localparam int EW   = (SW > SAMPLE_FIELD_W) ? SW : SAMPLE_FIELD_W;
   localparam int SUMW = SW + AW + 1;
   localparam int SQW  = 2 * SUMW;
   localparam int BW   = SQW + AW;
   localparam int NW   = BW + AW;
   localparam int NWE  = NW + (NW % 2);
   localparam int RW   = NWE / 2;
   localparam int TW   = $clog2(NW + 1);

   logic [SW-1:0]          mem [MAX_SAMPLES];
   logic [CW-1:0]          count_ff;
   logic                   ovf_ff;
   logic [LW-1:0]          lp_ff, k_ff;
   logic [AW-1:0]          idx_ff;
   logic [SW-1:0]          rd_data_ff;
   logic signed [SUMW-1:0] blk_ff, tot_ff;
   logic [SQW-1:0]         mcand_ff, prod_ff;
   logic [SUMW-1:0]        mplier_ff;
   logic [BW-1:0]          bsum_ff;
   logic [NW-1:0]          diff_ff, quo_ff;
   logic [AW-1:0]          rem_ff, dvs_ff;
   logic [NWE-1:0]         sqv_ff;
   logic [RW+1:0]          rrem_ff;
   logic [RW-1:0]          root_ff;
   logic [TW-1:0]          cnt_ff;
   rsp_beat_type           out_ff;

   logic [EW-1:0]          ext;
   logic [SW-1:0]          raw;
   logic [CW-1:0]          n1;
   logic [LW-1:0]          lp_calc;
   logic [AW-1:0]          blkmask, p_val;
   logic [LW-1:0]          j;
   logic signed [SUMW-1:0] x, s_n;
   logic [SUMW-1:0]        s_mag, t_mag;
   logic [AW:0]            r2;
   logic                   dge;
   logic [RW+3:0]          cand, trial;
   logic                   rge;
   logic [RW+31:0]         rext;
   logic                   sat;

   assign ext  = EW'($unsigned(req_beat.sample));
   assign raw  = ext[SW-1:0];
   assign n1   = count_ff - CW'(1);

   always_comb begin
      lp_calc = '0;
      for (int i = 1; i < CW; i++) begin
         if (n1[i]) lp_calc = LW'(i);
      end
   end

   assign blkmask = ~({AW{1'b1}} << k_ff);
   assign p_val   = AW'(1) << lp_ff;
   assign j       = lp_ff - k_ff;
   assign x       = SUMW'($signed(rd_data_ff));
   assign s_n     = blk_ff + x;
   assign s_mag   = s_n[SUMW-1] ? $unsigned(-s_n) : $unsigned(s_n);
   assign t_mag   = tot_ff[SUMW-1] ? $unsigned(-tot_ff) : $unsigned(tot_ff);

   // divider step
   assign r2  = {rem_ff, quo_ff[NW-1]};
   assign dge = r2 >= {1'b0, dvs_ff};

   // digit-by-digit root step
   assign cand  = {rrem_ff, sqv_ff[NWE-1:NWE-2]};
   assign trial = (RW+4)'({root_ff, 2'b01});
   assign rge   = cand >= trial;

   assign rext = (RW+32)'(root_ff);
   assign sat  = |rext[RW+31:32];

   assign sts.lvl_top   = (k_ff == lp_ff);
   assign sts.blk_end   = ((idx_ff & blkmask) == blkmask);
   assign sts.sweep_end = (idx_ff == p_val);
   assign sts.sq_done   = (cnt_ff == TW'(SUMW));
   assign sts.div_done  = (cnt_ff == TW'(NW));
   assign sts.root_done = (cnt_ff == TW'(RW));

   assign rsp_beat = out_ff;

   // sample memory
   always_ff @(posedge clock) begin
      if (op == OP_STORE && count_ff < CW'(MAX_SAMPLES)) begin
         mem[count_ff[AW-1:0]] <= raw;
      end
      if (op == OP_READ) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   // fill count and drop flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (finish) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (op == OP_STORE) begin
         if (count_ff < CW'(MAX_SAMPLES)) count_ff <= count_ff + CW'(1);
         else ovf_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      unique case (op)
         OP_SETUP: begin
            lp_ff <= lp_calc;
            k_ff  <= '0;
         end
         OP_LVL_INIT: begin
            idx_ff  <= '0;
            blk_ff  <= '0;
            tot_ff  <= '0;
            bsum_ff <= '0;
         end
         OP_ACC: begin
            tot_ff <= tot_ff + x;
            idx_ff <= idx_ff + AW'(1);
            if (sts.blk_end) begin
               blk_ff    <= '0;
               mcand_ff  <= SQW'(s_mag);
               mplier_ff <= s_mag;
               prod_ff   <= '0;
               cnt_ff    <= '0;
            end else begin
               blk_ff <= s_n;
            end
         end
         OP_SQ_STEP: begin
            if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
            cnt_ff    <= cnt_ff + TW'(1);
         end
         OP_BLK_ADD: begin
            bsum_ff <= bsum_ff + BW'(prod_ff);
            if (sts.sweep_end) begin
               mcand_ff  <= SQW'(t_mag);
               mplier_ff <= t_mag;
               prod_ff   <= '0;
               cnt_ff    <= '0;
            end
         end
         OP_NUM: begin
            diff_ff <= (NW'(bsum_ff) << j) - NW'(prod_ff);
         end
         OP_DIV_INIT: begin
            quo_ff <= diff_ff >> {lp_ff, 1'b0};
            dvs_ff <= ~({AW{1'b1}} << j);
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         OP_DIV_STEP: begin
            rem_ff <= dge ? AW'(r2 - {1'b0, dvs_ff}) : r2[AW-1:0];
            quo_ff <= {quo_ff[NW-2:0], dge};
            cnt_ff <= cnt_ff + TW'(1);
         end
         OP_SQRT_INIT: begin
            sqv_ff  <= NWE'(quo_ff);
            rrem_ff <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         OP_SQRT_STEP: begin
            rrem_ff <= rge ? (RW+2)'(cand - trial) : cand[RW+1:0];
            root_ff <= {root_ff[RW-2:0], rge};
            sqv_ff  <= sqv_ff << 2;
            cnt_ff  <= cnt_ff + TW'(1);
         end
         OP_OUT_DEF: begin
            out_ff.level      <= LEVEL_W'(k_ff);
            out_ff.std_error  <= sat ? {STD_W{1'b1}} : rext[STD_W-1:0];
            out_ff.defined    <= 1'b1;
            out_ff.overflowed <= ovf_ff;
            out_ff.final_res  <= 1'b0;
         end
         OP_OUT_UNDEF: begin
            out_ff.level      <= LEVEL_W'(k_ff);
            out_ff.std_error  <= '0;
            out_ff.defined    <= 1'b0;
            out_ff.overflowed <= ovf_ff;
            out_ff.final_res  <= 1'b1;
         end
         OP_NEXT: begin
            k_ff <= k_ff + LW'(1);
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/bseu_ctrl.sv =====
// controller: sequences loading, per-level sweep and arithmetic units
// depends on bseu_pkg and blocking_standard_error_unit_assert.svh
`include "blocking_standard_error_unit_assert.svh"
module bseu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  bseu_pkg::dp_status_type sts,
   output bseu_pkg::dp_op_type     op,
   output logic                    finish
);
   import bseu_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_LEVEL, ST_READ, ST_ACC, ST_SQ_BLK, ST_SQ_TOT,
      ST_DIV_INIT, ST_DIV, ST_SQRT, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, rsp_valid_ff;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      finish   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               op = OP_STORE;
               if (req_last) state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            op       = OP_SETUP;
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            if (sts.lvl_top) begin
               op       = OP_OUT_UNDEF;
               state_in = ST_OUT;
            end else begin
               op       = OP_LVL_INIT;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            op       = OP_READ;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            op       = OP_ACC;
            state_in = sts.blk_end ? ST_SQ_BLK : ST_READ;
         end
         ST_SQ_BLK: begin
            if (sts.sq_done) begin
               op       = OP_BLK_ADD;
               state_in = sts.sweep_end ? ST_SQ_TOT : ST_READ;
            end else begin
               op = OP_SQ_STEP;
            end
         end
         ST_SQ_TOT: begin
            if (sts.sq_done) begin
               op       = OP_NUM;
               state_in = ST_DIV_INIT;
            end else begin
               op = OP_SQ_STEP;
            end
         end
         ST_DIV_INIT: begin
            op       = OP_DIV_INIT;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               op       = OP_SQRT_INIT;
               state_in = ST_SQRT;
            end else begin
               op = OP_DIV_STEP;
            end
         end
         ST_SQRT: begin
            if (sts.root_done) begin
               op       = OP_OUT_DEF;
               state_in = ST_OUT;
            end else begin
               op = OP_SQRT_STEP;
            end
         end
         ST_OUT: begin
            if (rsp_valid_ff && rsp_ready) begin
               if (sts.lvl_top) begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  op       = OP_NEXT;
                  state_in = ST_LEVEL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
         rsp_valid_ff <= (state_in == ST_OUT);
      end
   end

   `BSEU_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid_ff, !req_ready_ff)
   `BSEU_ASSERT_NXT(a_last_blocks, clock, reset, req_valid && req_ready_ff && req_last, !req_ready_ff)
   `BSEU_ASSERT_NXT(a_final_frees, clock, reset, state_ff == ST_OUT && rsp_ready && sts.lvl_top, req_ready_ff)

endmodule

// ===== test/blocking_standard_error_unit_tb.sv =====
// testbench for blocking_standard_error_unit: drives sample sets, predicts every level result
// depends on bseu_pkg and the unit's rtl; self-checking, no files or arguments
`timescale 1ns / 100ps

module blocking_standard_error_unit_tb;
   import bseu_pkg::*;

   localparam int CAPACITY   = 4096;
   localparam int CYCLE_CAP  = 3000000;
   localparam int HOLD_LEN   = 400;
   localparam int RAND_ITEMS = 250;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_beat_type req_beat = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_beat_type rsp_beat;

   blocking_standard_error_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_beat(req_beat),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_beat(rsp_beat)
   );

   always #10 clock = ~clock;

   // predictor state: own copy of the sample memory, fill count and drop flag
   logic signed [31:0] sample_mem [CAPACITY];
   int                 fill_count = 0;
   bit                 dropped_any = 1'b0;
   rsp_beat_type       level_results [$];   // expected level beats, oldest first

   int  fail_count = 0;
   int  beats_sent = 0;
   int  beats_checked = 0;
   int  sets_closed = 0;
   int  cycle_count = 0;
   int  tx_idle = 0;     // sender idle percentage
   int  rx_idle = 0;     // receiver idle percentage
   bit  hold_armed = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;

   // exact blocking analysis over the stored set; appends one beat per level
   function automatic void analyze_set(ref rsp_beat_type res[$]);
      longint        top_pow;
      longint        blk;
      longint        blocks;
      longint        blk_sum;
      longint        total;
      logic [63:0]   mag_v;
      logic [127:0]  sq_sum;
      logic [127:0]  numer;
      logic [63:0]   denom;
      logic [63:0]   root;
      logic [63:0]   cand;
      logic [191:0]  prod;
      rsp_beat_type  r;
      int            lvl;
      top_pow = 1;
      while (top_pow * 2 < fill_count) top_pow *= 2;
      lvl = 0;
      for (blk = 1; blk <= top_pow; blk *= 2) begin
         blocks = top_pow / blk;
         r = '0;
         r.level = lvl[LEVEL_W-1:0];
         r.overflowed = dropped_any;
         r.final_res = (blk == top_pow);
         if (blocks >= 2) begin
            total = 0;
            sq_sum = '0;
            for (longint i = 0; i < blocks; i++) begin
               blk_sum = 0;
               for (longint j = 0; j < blk; j++) blk_sum += longint'(sample_mem[i * blk + j]);
               total += blk_sum;
               mag_v = (blk_sum < 0) ? -blk_sum : blk_sum;
               sq_sum += 128'(mag_v) * 128'(mag_v);
            end
            mag_v = (total < 0) ? -total : total;
            numer = sq_sum * 128'(blocks) - 128'(mag_v) * 128'(mag_v);
            denom = top_pow * top_pow * (blocks - 1);
            root = '0;
            for (int b = 31; b >= 0; b--) begin
               cand = root | (64'd1 << b);
               prod = 192'(cand) * 192'(cand) * 192'(denom);
               if (prod <= 192'(numer)) root = cand;
            end
            r.std_error = root[31:0];
            r.defined = 1'b1;
         end
         res = {res, r};
         lvl++;
      end
   endfunction

   // store or drop one accepted sample; on last, produce the level results
   function automatic void take_sample(input req_beat_type b, ref rsp_beat_type res[$]);
      if (fill_count < CAPACITY) begin
         sample_mem[fill_count] = b.sample;
         fill_count++;
      end else begin
         dropped_any = 1'b1;
      end
      if (b.last) begin
         analyze_set(res);
         fill_count = 0;
         dropped_any = 1'b0;
         sets_closed++;
      end
   endfunction

   // offer one beat, wait for acceptance, then queue what it should produce;
   // a typed expectation replaces the predicted one for that beat
   task automatic send_beat(input req_beat_type b, input bit typed, input rsp_beat_type want);
      rsp_beat_type produced [$];
      while ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= b;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      take_sample(b, produced);
      if (typed) begin
         level_results = {level_results, want};
      end else begin
         level_results = {level_results, produced};
      end
   endtask

   // random sample value with weight on extremes and small numbers
   function automatic logic signed [31:0] pick_sample();
      case ($urandom_range(5))
         0: pick_sample = 32'sh7fff_ffff;
         1: pick_sample = 32'sh8000_0000;
         2: pick_sample = $signed($urandom_range(200)) - 100;
         default: pick_sample = $urandom;
      endcase
   endfunction

   // receiver: random stalls, plus one long hold-off on a pending result, counted here
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done && rsp_valid) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle);
      end
   end

   // checker: each taken result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (level_results.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, rsp_beat);
            fail_count++;
         end else begin
            rsp_beat_type want;
            want = level_results.pop_front();
            beats_checked++;
            if (rsp_beat.level !== want.level) begin
               $display("%0t: level expected %0d actual %0d", $time, want.level, rsp_beat.level);
               fail_count++;
            end
            if (rsp_beat.std_error !== want.std_error) begin
               $display("%0t: std_error expected %0d actual %0d (level %0d)",
                        $time, want.std_error, rsp_beat.std_error, want.level);
               fail_count++;
            end
            if (rsp_beat.defined !== want.defined) begin
               $display("%0t: defined expected %0b actual %0b", $time, want.defined,
                        rsp_beat.defined);
               fail_count++;
            end
            if (rsp_beat.overflowed !== want.overflowed) begin
               $display("%0t: overflowed expected %0b actual %0b", $time, want.overflowed,
                        rsp_beat.overflowed);
               fail_count++;
            end
            if (rsp_beat.final_res !== want.final_res) begin
               $display("%0t: final_res expected %0b actual %0b", $time, want.final_res,
                        rsp_beat.final_res);
               fail_count++;
            end
         end
      end
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("%0t: timeout, %0d result beats still pending", $time, level_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   typedef struct {
      req_beat_type beat;
      bit           typed;
      rsp_beat_type want;
   } directed_row_type;

   // single-block beat: level 0, no spread defined, closes the set
   localparam rsp_beat_type ONE_BLOCK = '{level: 4'd0, std_error: 32'd0, defined: 1'b0,
                                          overflowed: 1'b0, final_res: 1'b1};

   directed_row_type directed [] = '{
      // one sample: single block
      '{'{32'sh7fff_ffff, 1'b1}, 1'b1, ONE_BLOCK},
      // two samples still give P = 1: single block
      '{'{32'sh8000_0000, 1'b0}, 1'b0, '0},
      '{'{32'sh8000_0000, 1'b1}, 1'b1, ONE_BLOCK},
      // three samples, P = 2
      '{'{32'sd1, 1'b0}, 1'b0, '0},
      '{'{32'sd2, 1'b0}, 1'b0, '0},
      '{'{32'sd3, 1'b1}, 1'b0, '0},
      // four samples with both extremes, P = 2
      '{'{32'sh7fff_ffff, 1'b0}, 1'b0, '0},
      '{'{32'sh8000_0000, 1'b0}, 1'b0, '0},
      '{'{32'sd0, 1'b0}, 1'b0, '0},
      '{'{-32'sd1, 1'b1}, 1'b0, '0},
      // nine samples, eight of them alternating extremes, P = 8, four levels
      '{'{32'sh7fff_ffff, 1'b0}, 1'b0, '0},
      '{'{32'sh8000_0000, 1'b0}, 1'b0, '0},
      '{'{32'sh7fff_ffff, 1'b0}, 1'b0, '0},
      '{'{32'sh8000_0000, 1'b0}, 1'b0, '0},
      '{'{32'sh7fff_ffff, 1'b0}, 1'b0, '0},
      '{'{32'sh8000_0000, 1'b0}, 1'b0, '0},
      '{'{32'sh7fff_ffff, 1'b0}, 1'b0, '0},
      '{'{32'sh8000_0000, 1'b0}, 1'b0, '0},
      '{'{32'sh5555_aaaa, 1'b1}, 1'b0, '0}
   };

   initial begin
      req_beat_type b;
      int           set_len;
      int           rand_sent;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, no idling
      foreach (directed[i]) send_beat(directed[i].beat, directed[i].typed, directed[i].want);

      // random sets; idling pattern changes by thirds, long receiver hold on the next pending result
      hold_armed = 1'b1;
      rand_sent = 0;
      while (rand_sent < RAND_ITEMS) begin
         if (rand_sent < RAND_ITEMS / 3) begin
            tx_idle = 26; rx_idle = 47;
         end else if (rand_sent < 2 * RAND_ITEMS / 3) begin
            tx_idle = 47; rx_idle = 26;
         end else begin
            tx_idle = 0; rx_idle = 0;
         end
         set_len = ($urandom_range(7) == 0) ? $urandom_range(80, 33) : $urandom_range(32, 1);
         if (set_len > RAND_ITEMS - rand_sent) set_len = RAND_ITEMS - rand_sent;
         for (int i = 0; i < set_len; i++) begin
            b.sample = pick_sample();
            b.last = (i == set_len - 1);
            send_beat(b, 1'b0, '0);
            rand_sent++;
         end
      end
      req_valid <= 1'b0;

      while (level_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d sample beats in %0d sets, %0d level results checked",
               beats_sent, sets_closed, beats_checked);
      $display("sets of one to eighty samples, extremes included, with stalls on both sides");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
